FILE: sv/sorted_table_lower_bound_search_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted table lower bound search
// Concurrent property wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_LOWER_BOUND_SEARCH_MACROS_SVH
`define SORTED_TABLE_LOWER_BOUND_SEARCH_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: sv/stlbs_pkg.sv
// ----------------------------------------------------------------------------
// stlbs_pkg
// Shared types and constants of the sorted table lower bound search.
// ----------------------------------------------------------------------------
`default_nettype none

package stlbs_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 4096;
    localparam int IDX_W               = 12;
    localparam int DATA_W              = 64;
    localparam int LEN_W               = 13;
    localparam int POS_W               = 13;

    typedef enum logic {
        FUNC_LOAD   = 1'b0,
        FUNC_SEARCH = 1'b1
    } func_t;

    // data holds the entry value for a load and the key for a search
    typedef struct packed {
        func_t              func;
        logic [IDX_W-1:0]   index;
        logic [DATA_W-1:0]  data;
    } stlbs_item_t;

endpackage

`default_nettype wire

FILE: sv/stlbs_level.sv
// ----------------------------------------------------------------------------
// stlbs_level
// One bisection step: private copy of the table, registered read of the
// midpoint entry, then compare and narrow [lo, hi). Loads write this copy
// as they pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_table_lower_bound_search_macros.svh"

module stlbs_level
    import stlbs_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
    parameter int PW          = $clog2(TABLE_DEPTH + 1)
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        adv,
    input  wire logic        in_valid,
    input  wire stlbs_item_t in_item,
    input  wire logic [PW-1:0] in_lo,
    input  wire logic [PW-1:0] in_hi,
    output logic             out_valid,
    output stlbs_item_t      out_item,
    output logic [PW-1:0]    out_lo,
    output logic [PW-1:0]    out_hi
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int XW = ((AW > IDX_W) ? AW : IDX_W) + 1;

    logic [DATA_W-1:0] mem [TABLE_DEPTH];

    logic [PW-1:0]   mid;
    logic [XW-1:0]   idx_ext;
    logic            wr_en;

    logic            rd_valid_reg;
    stlbs_item_t     rd_item_reg;
    logic [PW-1:0]   rd_lo_reg;
    logic [PW-1:0]   rd_hi_reg;
    logic [PW-1:0]   rd_mid_reg;
    logic [DATA_W-1:0] rd_data_reg;

    logic            active;
    logic            less;
    logic [PW-1:0]   lo_next;
    logic [PW-1:0]   hi_next;

    logic            out_valid_reg;
    stlbs_item_t     out_item_reg;
    logic [PW-1:0]   out_lo_reg;
    logic [PW-1:0]   out_hi_reg;

    assign mid     = in_lo + ((in_hi - in_lo) >> 1);
    assign idx_ext = XW'(in_item.index);
    assign wr_en   = in_valid && (in_item.func == FUNC_LOAD)
                     && (idx_ext < XW'(TABLE_DEPTH));

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (wr_en) begin
                mem[idx_ext[AW-1:0]] <= in_item.data;
            end
            rd_data_reg <= mem[mid[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            rd_valid_reg  <= in_valid;
            out_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rd_item_reg  <= in_item;
            rd_lo_reg    <= in_lo;
            rd_hi_reg    <= in_hi;
            rd_mid_reg   <= mid;
            out_item_reg <= rd_item_reg;
            out_lo_reg   <= lo_next;
            out_hi_reg   <= hi_next;
        end
    end

    always_comb begin
        active  = (rd_item_reg.func == FUNC_SEARCH) && (rd_lo_reg < rd_hi_reg);
        less    = $signed(rd_data_reg) < $signed(rd_item_reg.data);
        lo_next = rd_lo_reg;
        hi_next = rd_hi_reg;
        if (active) begin
            if (less) begin
                lo_next = rd_mid_reg + PW'(1);
            end else begin
                hi_next = rd_mid_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign out_lo    = out_lo_reg;
    assign out_hi    = out_hi_reg;

    `ASSERT_IMPLIES(a_range_ordered, aclk, aresetn,
        out_valid_reg && (out_item_reg.func == FUNC_SEARCH), out_lo_reg <= out_hi_reg)
    `ASSERT_IMPLIES(a_step_narrows, aclk, aresetn,
        rd_valid_reg && active, (lo_next > rd_lo_reg) || (hi_next < rd_hi_reg))
    `ASSERT_NEXT(a_stall_holds, aclk, aresetn,
        !adv, $stable(out_valid_reg) && $stable(out_lo_reg) && $stable(out_hi_reg))

endmodule

`default_nettype wire

FILE: sv/sorted_table_lower_bound_search.sv
// ----------------------------------------------------------------------------
// sorted_table_lower_bound_search
// Pipeline: one input stage, two stages per bisection level (midpoint
//   read of that level's table copy, compare), one output register.
// Throughput: one item per cycle; the whole pipeline holds while a result
//   waits at the output.
// Reset: synchronous, clears valid bits and table_length; table contents
//   stay undefined until loaded.
// Lower bound search over a signed 64-bit table, one table copy per level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_table_lower_bound_search_macros.svh"

module sorted_table_lower_bound_search
    import stlbs_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic [LEN_W-1:0]         cfg_wr_data,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic                     s_func,
    input  wire logic [IDX_W-1:0]         s_entry_index,
    input  wire logic signed [DATA_W-1:0] s_entry_value,
    input  wire logic signed [DATA_W-1:0] s_search_key,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [POS_W-1:0]              m_position
);

    localparam int LEVELS = $clog2(TABLE_DEPTH + 1);
    localparam int PW     = LEVELS;
    localparam int LW     = (PW > LEN_W) ? PW : LEN_W;
    localparam int OW     = (PW > POS_W) ? PW : POS_W;

    logic               adv;
    logic [LEN_W-1:0]   len_reg;
    logic [LW-1:0]      len_ext;
    logic [LW-1:0]      hi_full;

    logic               in_valid_reg;
    stlbs_item_t        in_item_reg;
    logic [PW-1:0]      in_hi_reg;
    stlbs_item_t        item_next;

    logic               lv_valid [LEVELS+1];
    stlbs_item_t        lv_item  [LEVELS+1];
    logic [PW-1:0]      lv_lo    [LEVELS+1];
    logic [PW-1:0]      lv_hi    [LEVELS+1];

    logic               m_valid_reg;
    logic [POS_W-1:0]   m_position_reg;
    logic [OW-1:0]      pos_ext;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else if (cfg_wr_en) begin
            len_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        len_ext         = LW'(len_reg);
        hi_full         = (len_ext > LW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : len_ext;
        item_next.func  = func_t'(s_func);
        item_next.index = s_entry_index;
        item_next.data  = (func_t'(s_func) == FUNC_SEARCH) ? s_search_key : s_entry_value;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_item_reg <= item_next;
            in_hi_reg   <= hi_full[PW-1:0];
        end
    end

    assign lv_valid[0] = in_valid_reg;
    assign lv_item[0]  = in_item_reg;
    assign lv_lo[0]    = '0;
    assign lv_hi[0]    = in_hi_reg;

    for (genvar g = 0; g < LEVELS; g++) begin : g_level
        stlbs_level #(
            .TABLE_DEPTH(TABLE_DEPTH),
            .PW         (PW)
        ) u_level (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .in_valid (lv_valid[g]),
            .in_item  (lv_item[g]),
            .in_lo    (lv_lo[g]),
            .in_hi    (lv_hi[g]),
            .out_valid(lv_valid[g+1]),
            .out_item (lv_item[g+1]),
            .out_lo   (lv_lo[g+1]),
            .out_hi   (lv_hi[g+1])
        );
    end

    assign pos_ext = OW'(lv_lo[LEVELS]);

    // drop load items at the output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= lv_valid[LEVELS] && (lv_item[LEVELS].func == FUNC_SEARCH);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_position_reg <= pos_ext[POS_W-1:0];
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_position = m_position_reg;

    `ASSERT_NEXT(a_load_no_result, aclk, aresetn,
        adv && lv_valid[LEVELS] && (lv_item[LEVELS].func == FUNC_LOAD), !m_valid_reg)
    `ASSERT_NEXT(a_accept_enters, aclk, aresetn,
        s_valid && s_ready, in_valid_reg)
    `ASSERT_NEXT(a_result_holds, aclk, aresetn,
        m_valid_reg && !m_ready, m_valid_reg && $stable(m_position_reg))

endmodule

`default_nettype wire
